/* rtl/core/rhsm_pkg.sv */
// Shared constants, types and modular arithmetic helpers for the rolling hash matcher.
`default_nettype none

package rhsm_pkg;

  localparam int unsigned MAX_PAT_DEF = 64;

  localparam int HASH_W = 30;
  localparam int PROD_W = 37;
  localparam int LO_W   = 29;
  localparam int CMD_W  = 2;
  localparam int CH_W   = 7;
  localparam int POS_W  = 32;

  localparam logic [HASH_W-1:0] HASH_MOD  = 30'd1000000007;
  localparam logic [HASH_W:0]   MOD_EXT   = {1'b0, HASH_MOD};
  localparam logic [4:0]        HASH_BASE = 5'd31;
  localparam logic [CH_W-1:0]   CH_BIAS   = 7'd96;
  localparam logic [POS_W-1:0]  COUNT_MAX = 32'hFFFF_FFFF;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OCC_W     = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PAT,
    OP_TXT
  } acc_op_t;

  typedef struct packed {
    acc_op_t            op;
    logic               neg;
    logic               win;
    logic               pre;
    logic               ovf;
    logic [POS_W-1:0]   start;
    logic [HASH_W-1:0]  tgt;
  } pipe_t;

  typedef struct packed {
    logic              match;
    logic [POS_W-1:0]  start_pos;
    logic              pattern_overflow;
  } res_t;

  typedef logic [HASH_W-1:0] hi_tbl_t [256];

  // Residues of h * 2^LO_W, built by repeated add and fold.
  function automatic hi_tbl_t build_hi_tbl();
    hi_tbl_t          t;
    logic [HASH_W:0]  acc;
    acc = '0;
    for (int k = 0; k < 256; k++) begin
      t[k] = acc[HASH_W-1:0];
      acc = acc + ((HASH_W+1)'(1) << LO_W);
      if (acc >= MOD_EXT) begin
        acc = acc - MOD_EXT;
      end
    end
    return t;
  endfunction

  localparam hi_tbl_t HI_TBL = build_hi_tbl();

  function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                                input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MOD_EXT) begin
      s = s - MOD_EXT;
    end
    return s[HASH_W-1:0];
  endfunction

  function automatic logic [HASH_W-1:0] mod_sub(input logic [HASH_W-1:0] a,
                                                input logic [HASH_W-1:0] b);
    logic [HASH_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + MOD_EXT - {1'b0, b};
    end
    return s[HASH_W-1:0];
  endfunction

  // Fold a product below 2^PROD_W: table residue of the top byte plus the low bits
  // stays below twice the modulus, so one conditional subtract finishes it.
  function automatic logic [HASH_W-1:0] reduce_wide(input logic [PROD_W-1:0] x);
    logic [HASH_W:0] s;
    s = {1'b0, HI_TBL[x[PROD_W-1:LO_W]]} + (HASH_W+1)'(x[LO_W-1:0]);
    if (s >= MOD_EXT) begin
      s = s - MOD_EXT;
    end
    return s[HASH_W-1:0];
  endfunction

  function automatic logic [PROD_W-1:0] times_base(input logic [HASH_W-1:0] p);
    return PROD_W'(p) * PROD_W'(HASH_BASE);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rhsm_if.sv */
// Valid/ready channel interfaces for the input and result transactions.
`default_nettype none

interface rhsm_in_if import rhsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CH_W-1:0]   ch;

  modport source (output valid, cmd, ch, input ready);
  modport sink   (input valid, cmd, ch, output ready);
endinterface

interface rhsm_out_if import rhsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              match;
  logic [POS_W-1:0]  start_pos;
  logic              pattern_overflow;

  modport source (output valid, match, start_pos, pattern_overflow, input ready);
  modport sink   (input valid, match, start_pos, pattern_overflow, output ready);
endinterface

`default_nettype wire

/* rtl/core/rolling_hash_substring_match.sv */
// Rabin-Karp substring matcher over a letter stream, top level.
//
// Usage: every input transaction on in_chan carries a command (clear, append a
// pattern letter, process a text letter) and a letter. Every input transaction
// yields exactly one result transaction on out_chan: match flag, start index of
// the matching window and a pattern overflow flag; results keep input order.
// Results: an accepted transaction passes stages s1, s2 and s3 and is then
// written to the result queue, whose nonempty state drives out_chan.valid.
// Pacing: no transaction is accepted back to back with the previous one. This
// is set by the loops that step the base powers and the scaled pattern hash by
// 31 modulo 1e9+7: one step forms 31*x, a second folds it through the residue table.
// The letter weight multiply, its fold and the prefix accumulate run in a
// three-stage pipeline; the prefix ring, a synchronous memory with a registered
// read port, is read one stage after acceptance and written two stages after.
// Reset (synchronous, active low) returns all hash state to its initial values
// and empties the pipeline and result queue; the ring needs no clearing pass.
// Stall: results wait in a four-entry queue; in_chan.ready drops while four
// transactions are outstanding, so a stalled receiver never loses a result.
`default_nettype none

module rolling_hash_substring_match import rhsm_pkg::*; #(
  parameter int unsigned MAX_PAT = MAX_PAT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rhsm_in_if.sink     in_chan,
  rhsm_out_if.source  out_chan
);

  localparam int LEN_W  = $clog2(MAX_PAT + 1);
  localparam int ADDR_W = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;

  // Hash state
  logic [HASH_W-1:0] ph_r, ph_nxt;            // pattern hash
  logic [LEN_W-1:0]  len_r, len_nxt;          // pattern length
  logic [HASH_W-1:0] pat_pow_r, pat_pow_nxt;  // 31^len
  logic [HASH_W-1:0] prefix_r, prefix_nxt;    // running text prefix hash
  logic [HASH_W-1:0] txt_pow_r, txt_pow_nxt;  // 31^count
  logic [HASH_W-1:0] tgt_r, tgt_nxt;          // pattern hash scaled by 31^start
  logic [POS_W-1:0]  count_r, count_nxt;      // text position
  logic [ADDR_W-1:0] wp_r, wp_nxt;            // ring slot of the current position

  // Base multiply loops
  logic              pw_pend_r, pw_pend_nxt;
  logic              pw_pat_r;
  logic [PROD_W-1:0] py_r;
  logic              tg_pend_r, tg_pend_nxt;
  logic [PROD_W-1:0] ty_r;

  // Pipeline
  logic              s1_vld_r, s2_vld_r, s3_vld_r;
  pipe_t             s1_nxt, s1_r, s2_r, s3_r;
  logic [PROD_W-1:0] s1_prod_r;
  logic [ADDR_W-1:0] s1_wa_r, s1_ra_r, s2_wa_r;
  logic [HASH_W-1:0] s2_red_r;
  logic [HASH_W-1:0] s3_acc_r;

  // Result queue
  res_t              fifo_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OCC_W-1:0]  fifo_cnt_r;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic              cool_r;

  logic              in_acc, push, pop;
  logic              is_pat, pat_room, txt_ok, win_c;
  logic              neg;
  logic [CH_W-1:0]   mag;
  logic [HASH_W-1:0] pow_sel;
  logic [PROD_W-1:0] prod_in;
  logic [LEN_W:0]    ra_sum;
  logic [ADDR_W-1:0] ra_in;
  logic              s2_pat_done;
  logic [HASH_W-1:0] acc_base, acc_new, ph_cur, tgt_cur;
  logic [HASH_W-1:0] rd_data, prior_hash, wh;
  res_t              res_new;

  // ---------------------------------------------------------------------------
  // Handshake. Acceptances never come back to back (cool_r); the queue plus the
  // pipeline never hold more than OUT_DEPTH outstanding transactions.
  // ---------------------------------------------------------------------------
  assign in_chan.ready = !cool_r && (occ_r != OCC_W'(OUT_DEPTH));
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign pop           = out_chan.valid && out_chan.ready;
  assign push          = s3_vld_r;

  // ---------------------------------------------------------------------------
  // Decode at acceptance
  // ---------------------------------------------------------------------------
  assign is_pat   = (in_chan.cmd == CMD_PATTERN);
  assign txt_ok   = (in_chan.cmd == CMD_TEXT) && (count_r != COUNT_MAX);
  assign pat_room = (len_r < LEN_W'(MAX_PAT));
  assign win_c    = (len_r != '0) && (({1'b0, count_r} + 33'd1) >= 33'(len_r));

  // Letter weight is ch - 96, a signed value; carry magnitude and sign.
  assign neg     = (in_chan.ch < CH_BIAS);
  assign mag     = neg ? (CH_BIAS - in_chan.ch) : (in_chan.ch - CH_BIAS);
  assign pow_sel = is_pat ? pat_pow_r : txt_pow_r;
  assign prod_in = PROD_W'(mag) * PROD_W'(pow_sel);

  // Slot of the prefix just before the window: (position - length) around the ring.
  always_comb begin
    if ((LEN_W+1)'(wp_r) >= (LEN_W+1)'(len_r)) begin
      ra_sum = (LEN_W+1)'(wp_r) - (LEN_W+1)'(len_r);
    end else begin
      ra_sum = (LEN_W+1)'(wp_r) + (LEN_W+1)'(MAX_PAT) - (LEN_W+1)'(len_r);
    end
  end
  assign ra_in = ra_sum[ADDR_W-1:0];

  // Accumulate stage; a pattern accumulate finishing now is forwarded to the
  // transaction being accepted in the same cycle.
  assign s2_pat_done = s2_vld_r && (s2_r.op == OP_PAT);
  assign acc_base    = (s2_r.op == OP_PAT) ? ph_r : prefix_r;
  assign acc_new     = s2_r.neg ? mod_sub(acc_base, s2_red_r) : mod_add(acc_base, s2_red_r);
  assign ph_cur      = s2_pat_done ? acc_new : ph_r;
  assign tgt_cur     = s2_pat_done ? acc_new : tgt_r;

  always_comb begin
    s1_nxt.op    = OP_NONE;
    s1_nxt.neg   = neg;
    s1_nxt.win   = txt_ok && win_c;
    s1_nxt.pre   = txt_ok && win_c && (count_r >= 32'(len_r));
    s1_nxt.ovf   = is_pat && !pat_room;
    s1_nxt.start = count_r + 32'd1 - 32'(len_r);
    s1_nxt.tgt   = tgt_cur;
    if (is_pat && pat_room) begin
      s1_nxt.op = OP_PAT;
    end else if (txt_ok) begin
      s1_nxt.op = OP_TXT;
    end
  end

  // ---------------------------------------------------------------------------
  // Next state. Order: finish the base multiplies, then the accumulate stage,
  // then the accepted command (clear and restart override everything before).
  // ---------------------------------------------------------------------------
  always_comb begin
    ph_nxt      = ph_r;
    len_nxt     = len_r;
    pat_pow_nxt = pat_pow_r;
    prefix_nxt  = prefix_r;
    txt_pow_nxt = txt_pow_r;
    tgt_nxt     = tgt_r;
    count_nxt   = count_r;
    wp_nxt      = wp_r;
    pw_pend_nxt = 1'b0;
    tg_pend_nxt = 1'b0;

    if (pw_pend_r) begin
      if (pw_pat_r) begin
        pat_pow_nxt = reduce_wide(py_r);
      end else begin
        txt_pow_nxt = reduce_wide(py_r);
      end
    end
    if (tg_pend_r) begin
      tgt_nxt = reduce_wide(ty_r);
    end
    if (s2_pat_done) begin
      ph_nxt  = acc_new;
      tgt_nxt = acc_new;
    end
    if (s2_vld_r && (s2_r.op == OP_TXT)) begin
      prefix_nxt = acc_new;
    end

    if (in_acc) begin
      case (in_chan.cmd)
        CMD_CLEAR: begin
          ph_nxt      = '0;
          len_nxt     = '0;
          pat_pow_nxt = HASH_W'(1);
          prefix_nxt  = '0;
          txt_pow_nxt = HASH_W'(1);
          tgt_nxt     = '0;
          count_nxt   = '0;
          wp_nxt      = '0;
        end
        CMD_PATTERN: begin
          if (pat_room) begin
            len_nxt     = len_r + 1'b1;
            pw_pend_nxt = 1'b1;
          end
          // restart text progress; window scale back to 31^0
          prefix_nxt  = '0;
          txt_pow_nxt = HASH_W'(1);
          tgt_nxt     = ph_cur;
          count_nxt   = '0;
          wp_nxt      = '0;
        end
        CMD_TEXT: begin
          if (txt_ok) begin
            pw_pend_nxt = 1'b1;
            tg_pend_nxt = win_c;
            count_nxt   = count_r + 32'd1;
            wp_nxt      = (wp_r == ADDR_W'(MAX_PAT - 1)) ? '0 : (wp_r + 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign occ_nxt = occ_r + OCC_W'(in_acc) - OCC_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r       <= '0;
      len_r      <= '0;
      pat_pow_r  <= HASH_W'(1);
      prefix_r   <= '0;
      txt_pow_r  <= HASH_W'(1);
      tgt_r      <= '0;
      count_r    <= '0;
      wp_r       <= '0;
      pw_pend_r  <= 1'b0;
      tg_pend_r  <= 1'b0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      cool_r     <= 1'b0;
      occ_r      <= '0;
    end else begin
      ph_r       <= ph_nxt;
      len_r      <= len_nxt;
      pat_pow_r  <= pat_pow_nxt;
      prefix_r   <= prefix_nxt;
      txt_pow_r  <= txt_pow_nxt;
      tgt_r      <= tgt_nxt;
      count_r    <= count_nxt;
      wp_r       <= wp_nxt;
      pw_pend_r  <= pw_pend_nxt;
      tg_pend_r  <= tg_pend_nxt;
      s1_vld_r   <= in_acc;
      s2_vld_r   <= s1_vld_r;
      s3_vld_r   <= s2_vld_r;
      cool_r     <= in_acc;
      occ_r      <= occ_nxt;
    end
  end

  // Payload registers: multiply inputs of the base loops and pipeline stages.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pw_pat_r  <= is_pat;
      py_r      <= times_base(pow_sel);
      ty_r      <= times_base(tgt_cur);
      s1_r      <= s1_nxt;
      s1_prod_r <= prod_in;
      s1_wa_r   <= wp_r;
      s1_ra_r   <= ra_in;
    end
    if (s1_vld_r) begin
      s2_r     <= s1_r;
      s2_red_r <= reduce_wide(s1_prod_r);
      s2_wa_r  <= s1_wa_r;
    end
    if (s2_vld_r) begin
      s3_r     <= s2_r;
      s3_acc_r <= acc_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Prefix ring: read one stage after acceptance, so the previous transaction's
  // write two stages after its acceptance has already landed.
  // ---------------------------------------------------------------------------
  rhsm_ring #(
    .DEPTH  (MAX_PAT),
    .ADDR_W (ADDR_W)
  ) u_ring (
    .clk       (clk),
    .wr_en     (s2_vld_r && (s2_r.op == OP_TXT)),
    .wr_addr   (s2_wa_r),
    .wr_data   (acc_new),
    .rd_en     (s1_vld_r && s1_r.pre),
    .rd_addr   (s1_ra_r),
    .rd_data_r (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Window compare and result
  // ---------------------------------------------------------------------------
  assign prior_hash = s3_r.pre ? rd_data : '0;
  assign wh         = mod_sub(s3_acc_r, prior_hash);

  always_comb begin
    res_new.match            = s3_r.win && (wh == s3_r.tgt);
    res_new.start_pos        = res_new.match ? s3_r.start : '0;
    res_new.pattern_overflow = s3_r.ovf;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_q[wr_ptr_r] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fifo_cnt_r <= fifo_cnt_r + OCC_W'(push) - OCC_W'(pop);
    end
  end

  assign out_chan.valid            = (fifo_cnt_r != '0);
  assign out_chan.match            = fifo_q[rd_ptr_r].match;
  assign out_chan.start_pos        = fifo_q[rd_ptr_r].start_pos;
  assign out_chan.pattern_overflow = fifo_q[rd_ptr_r].pattern_overflow;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The base loops form and then fold a product; back-to-back transactions would break them.
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_acc)
    else $error("input transactions accepted in consecutive cycles");

  // Every accepted transaction reaches the result queue through the pipeline stages.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##3 push)
    else $error("accepted transaction did not produce a result");

  // The outstanding count must keep the queue from overflowing.
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && (fifo_cnt_r == OCC_W'(OUT_DEPTH))))
    else $error("result queue overflow");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_PAT))
    else $error("pattern length beyond capacity");

endmodule

`default_nettype wire

/* rtl/core/rhsm_ring.sv */
// Prefix hash ring: one write port, one registered read port.
`default_nettype none

module rhsm_ring import rhsm_pkg::*; #(
  parameter int unsigned DEPTH  = MAX_PAT_DEF,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [HASH_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [HASH_W-1:0] rd_data_r
);

  logic [HASH_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the rolling hash substring matcher.
`timescale 1ns / 100ps

module tb_top import rhsm_pkg::*; ();

  localparam longint unsigned MODULUS      = 64'd1000000007;
  localparam longint unsigned MULT         = 64'd31;
  localparam longint unsigned TEXT_POS_MAX = 64'hFFFF_FFFF;
  localparam int unsigned     RING_DEPTH   = MAX_PAT_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam logic [CH_W-1:0]  LETTER_A    = 7'd97;
  localparam logic [CH_W-1:0]  LETTER_Z    = 7'd122;
  localparam logic [CH_W-1:0]  CH_LOWEST   = 7'd0;
  localparam logic [CH_W-1:0]  CH_HIGHEST  = 7'd127;

  localparam int STREAM_ITEMS = 1250;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CH_W-1:0]  ch;
  } stream_item_t;

  logic clk;
  logic rst_n;

  rhsm_in_if  in_chan ();
  rhsm_out_if out_chan ();

  rolling_hash_substring_match dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #6 clk = ~clk;

  // Items waiting to be driven, and the results predicted for accepted items.
  stream_item_t letters_pending[$];
  res_t         results_due[$];

  int total_items;
  int accepted_items;
  int result_index;
  int fail_count;
  int idle_cycles;
  logic in_took;

  // Shadow of the matcher: pattern hash, text prefix hash and the prefix ring.
  longint unsigned pat_hash;
  longint unsigned pat_pow;
  longint unsigned pat_len;
  longint unsigned txt_prefix;
  longint unsigned txt_pow;
  longint unsigned win_pow;
  longint unsigned text_pos;
  longint unsigned prefix_hist[RING_DEPTH];

  // Drop all text progress; the pattern is kept.
  function automatic void restart_text();
    txt_prefix = 0;
    txt_pow    = 1;
    win_pow    = 1;
    text_pos   = 0;
  endfunction

  function automatic void clear_matcher();
    pat_hash = 0;
    pat_len  = 0;
    pat_pow  = 1;
    restart_text();
    foreach (prefix_hist[k]) prefix_hist[k] = 0;
  endfunction

  // Advance the shadow by one transaction and return the result it must produce.
  function automatic res_t predict_match(input logic [CMD_W-1:0] cmd,
                                         input logic [CH_W-1:0]  ch);
    res_t            r;
    longint unsigned val;
    longint unsigned win_start;
    longint unsigned prior_prefix;
    longint unsigned window_hash;
    bit              in_window;
    r   = '0;
    val = (longint'(ch) + MODULUS - 96) % MODULUS;
    case (cmd)
      CMD_CLEAR: begin
        clear_matcher();
      end
      CMD_PATTERN: begin
        if (pat_len < RING_DEPTH) begin
          pat_hash = (pat_hash + val * pat_pow % MODULUS) % MODULUS;
          pat_pow  = pat_pow * MULT % MODULUS;
          pat_len++;
        end else begin
          r.pattern_overflow = 1'b1;
        end
        // A pattern letter restarts the text pass even when it is dropped.
        restart_text();
      end
      CMD_TEXT: begin
        // Once the text position saturates, text letters change nothing.
        if (text_pos != TEXT_POS_MAX) begin
          in_window    = (pat_len != 0) && (text_pos + 1 >= pat_len);
          prior_prefix = 0;
          win_start    = 0;
          txt_prefix   = (txt_prefix + val * txt_pow % MODULUS) % MODULUS;
          txt_pow      = txt_pow * MULT % MODULUS;
          // Read the prefix just ahead of the window before its slot is reused.
          if (in_window) begin
            win_start = text_pos + 1 - pat_len;
            if (win_start > 0) prior_prefix = prefix_hist[(win_start - 1) % RING_DEPTH];
          end
          prefix_hist[text_pos % RING_DEPTH] = txt_prefix;
          if (in_window) begin
            window_hash = (txt_prefix + MODULUS - prior_prefix) % MODULUS;
            if (window_hash == pat_hash * win_pow % MODULUS) begin
              r.match     = 1'b1;
              r.start_pos = win_start[POS_W-1:0];
            end
            win_pow = win_pow * MULT % MODULUS;
          end
          text_pos = text_pos + 1;
        end
      end
      default: begin
        // The unused command leaves everything as it is.
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_REPORTS) $display("ERROR result %0d: %s", result_index, msg);
    fail_count++;
  endtask

  function automatic void queue_item(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch);
    stream_item_t it;
    it.cmd = cmd;
    it.ch  = ch;
    letters_pending.insert(letters_pending.size(), it);
  endfunction

  function automatic logic [CH_W-1:0] pick_letter(input int alphabet);
    // Slip in an occasional out-of-range code so every bit of ch toggles.
    if ($urandom_range(0, 29) == 0) return CH_W'($urandom_range(0, 127));
    return LETTER_A + CH_W'($urandom_range(0, alphabet - 1));
  endfunction

  // Build one search: optional clear, a pattern, then text that often holds it.
  task automatic add_search_run(input bit fill_pattern);
    logic [CH_W-1:0] pat[$];
    int alphabet;
    int plen;
    int tlen;
    int pos;
    if (fill_pattern || $urandom_range(0, 3) != 0)
      queue_item(CMD_CLEAR, CH_W'($urandom_range(0, 127)));
    alphabet = ($urandom_range(0, 5) == 0) ? 26 : $urandom_range(1, 3);
    if (fill_pattern)                    plen = RING_DEPTH;
    else if ($urandom_range(0, 9) == 0)  plen = $urandom_range(7, RING_DEPTH);
    else                                 plen = $urandom_range(1, 6);
    for (int k = 0; k < plen; k++) begin
      pat.insert(pat.size(), pick_letter(alphabet));
      queue_item(CMD_PATTERN, pat[k]);
    end
    // Push past a full pattern store so the overflow flag gets exercised.
    if (fill_pattern)
      repeat ($urandom_range(1, 3)) queue_item(CMD_PATTERN, pick_letter(alphabet));
    if (fill_pattern)                   tlen = $urandom_range(90, 150);
    else if ($urandom_range(0, 7) == 0) tlen = $urandom_range(65, 140);
    else                                tlen = $urandom_range(4, 30);
    pos = 0;
    while (pos < tlen) begin
      if (tlen - pos >= plen && $urandom_range(0, 3) == 0) begin
        foreach (pat[k]) queue_item(CMD_TEXT, pat[k]);
        pos += plen;
      end else begin
        queue_item(CMD_TEXT, pick_letter(alphabet));
        pos++;
      end
      // Break the run now and then with a stray command.
      if ($urandom_range(0, 59) == 0)
        queue_item(2'($urandom_range(0, 3)), CH_W'($urandom_range(0, 127)));
    end
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 8))
      queue_item(2'($urandom_range(0, 3)), CH_W'($urandom_range(0, 127)));
  endtask

  // Sender: bursts of random length separated by random gaps; hold a
  // transaction until it is taken.
  int burst_left;
  int gap_left;

  always @(negedge clk) begin
    stream_item_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!(in_chan.valid && !in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_chan.valid <= 1'b0;
        in_chan.cmd   <= 2'($urandom_range(0, 3));
        in_chan.ch    <= CH_W'($urandom_range(0, 127));
      end else if (letters_pending.size() > 0) begin
        nxt = letters_pending.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.cmd   <= nxt.cmd;
        in_chan.ch    <= nxt.ch;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          // A quarter of the bursts follow on without any gap.
          if ($urandom_range(0, 3) == 0)      gap_left = 0;
          else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(9, 20);
          else                                gap_left = $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Receiver: rotate through stall styles: always ready, random, periodic and random stall bursts.
  int rx_cycle;
  int stall_left;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      rx_cycle++;
      case ((rx_cycle / 256) % 4)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= ($urandom_range(0, 3) != 0);
        2: out_chan.ready <= ((rx_cycle % 8) < 3);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_chan.ready <= 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(4, 16);
            out_chan.ready <= 1'b0;
          end else begin
            out_chan.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Monitor: predict on every accepted input transaction, check every
  // accepted result against the oldest prediction, and watch for a hang.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      in_took     <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_took <= in_chan.valid && in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        results_due.insert(results_due.size(), predict_match(in_chan.cmd, in_chan.ch));
        accepted_items++;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          want = results_due.pop_front();
          if (out_chan.match !== want.match)
            report_mismatch($sformatf("match %b, want %b", out_chan.match, want.match));
          if (out_chan.start_pos !== want.start_pos)
            report_mismatch($sformatf("start_pos %0d, want %0d",
                                      out_chan.start_pos, want.start_pos));
          if (out_chan.pattern_overflow !== want.pattern_overflow)
            report_mismatch($sformatf("pattern_overflow %b, want %b",
                                      out_chan.pattern_overflow, want.pattern_overflow));
        end
        result_index++;
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR no transaction for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.cmd    = CMD_CLEAR;
    in_chan.ch     = CH_LOWEST;
    out_chan.ready = 1'b0;
    burst_left     = 1;
    gap_left       = 0;
    stall_left     = 0;
    rx_cycle       = 0;
    accepted_items = 0;
    result_index   = 0;
    fail_count     = 0;
    clear_matcher();

    // Directed opening: text with no pattern, out-of-range codes as pattern
    // and text, the unused command, a multi-letter pattern matched twice and
    // then extended (which restarts the text pass).
    queue_item(CMD_CLEAR, LETTER_A);
    queue_item(CMD_TEXT, LETTER_A);
    queue_item(CMD_TEXT, LETTER_Z);
    queue_item(CMD_PATTERN, CH_LOWEST);
    queue_item(CMD_TEXT, CH_LOWEST);
    queue_item(CMD_UNUSED, CH_HIGHEST);
    queue_item(CMD_TEXT, CH_LOWEST);
    queue_item(CMD_CLEAR, CH_HIGHEST);
    queue_item(CMD_PATTERN, LETTER_A);
    queue_item(CMD_PATTERN, LETTER_Z);
    queue_item(CMD_TEXT, LETTER_A);
    queue_item(CMD_TEXT, LETTER_Z);
    queue_item(CMD_TEXT, LETTER_A);
    queue_item(CMD_TEXT, LETTER_Z);
    queue_item(CMD_PATTERN, LETTER_A);
    queue_item(CMD_TEXT, LETTER_A);
    queue_item(CMD_TEXT, LETTER_Z);
    queue_item(CMD_TEXT, LETTER_A);
    queue_item(CMD_TEXT, CH_HIGHEST);
    queue_item(CMD_UNUSED, CH_LOWEST);
    queue_item(CMD_CLEAR, CH_LOWEST);

    // Random part: mostly well-formed searches, some noise. Lead with a full
    // pattern store so overflow shows up early. Text position saturation
    // needs 2^32 - 1 text letters and is out of reach here.
    add_search_run(1'b1);
    while (letters_pending.size() < STREAM_ITEMS) begin
      if ($urandom_range(0, 9) < 7)       add_search_run($urandom_range(0, 19) == 0);
      else                                add_noise();
    end
    total_items = letters_pending.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction to be taken and answered, then let the
    // pipeline drain to catch any stray result.
    do @(negedge clk);
    while (accepted_items != total_items || results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", results_due.size()));
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/rhsm_pkg.sv
rtl/core/rhsm_if.sv
rtl/core/rhsm_ring.sv
rtl/core/rolling_hash_substring_match.sv
test/tb_top.sv
